// ===== rtl/core/acp_pkg.sv =====
// shared types, constants and a helper function of the ascii register command parser
// used by every module under rtl/core; depends on nothing else
`default_nettype none

package acp_pkg;

    localparam int REG_COUNT  = 14;
    localparam int MSG_BYTES  = 24;
    localparam int IDX_W      = $clog2(REG_COUNT);
    localparam int CNT_W      = $clog2(MSG_BYTES + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SERVO_LO   = 2;
    localparam int SERVO_HI   = 6;

    localparam logic [7:0]  CH_WRITE    = 8'd87;
    localparam logic [7:0]  CH_READ     = 8'd82;
    localparam logic [7:0]  CH_COLON    = 8'd58;
    localparam logic [7:0]  CH_ZERO     = 8'd48;
    localparam logic [7:0]  CH_NINE     = 8'd57;
    localparam logic [15:0] RESET_SERVO = 16'd1500;
    localparam logic [7:0]  IDX_SAT     = 8'd255;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_INDEX,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        K_NONE,
        K_WRITE,
        K_READ,
        K_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_SEND
    } t_bstate;

    typedef enum logic [1:0] {
        SEG_W,
        SEG_IDX,
        SEG_COLON,
        SEG_VAL
    } t_seg;

    // one decoded command, index already known to be in range
    typedef struct packed {
        logic              is_write;
        logic [IDX_W-1:0]  idx;
        logic [15:0]       value;
    } t_cmd;

    // tens digit of a value below 100, reciprocal multiply
    function automatic logic [3:0] f_tens(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acp_front.sv =====
// front end: accepts received bytes, tracks message phase and decimal accumulators
// pushes a decoded write or read command on the final byte; uses acp_pkg
`default_nettype none

module acp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  wire                 s_axis_tlast,   // end_of_message
    input  wire                 i_full,
    output logic                o_push,
    output acp_pkg::t_cmd       o_cmd
);
    import acp_pkg::*;

    t_phase            r_phase, n_phase;
    t_kind             r_kind, n_kind;
    logic [7:0]        r_idx, n_idx;
    logic [15:0]       r_value, n_value;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              accept;
    logic              is_digit;
    logic [3:0]        dval;
    logic [11:0]       idx_mac;
    logic [15:0]       val_mac;
    logic              fin;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_digit      = s_axis_tdata inside {[CH_ZERO:CH_NINE]};
    assign dval          = s_axis_tdata[3:0];
    assign idx_mac       = {4'b0, r_idx} * 12'd10 + {8'b0, dval};
    assign val_mac       = r_value * 16'd10 + {12'b0, dval};
    assign fin           = accept && s_axis_tlast;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_idx   = r_idx;
        n_value = r_value;
        n_count = r_count;
        if (accept && (r_count < CNT_W'(MSG_BYTES))) begin
            n_count = r_count + CNT_W'(1);
            case (r_phase)
                PH_CMD: begin
                    if (s_axis_tdata == CH_WRITE) begin
                        n_kind  = K_WRITE;
                        n_phase = PH_INDEX;
                    end else if (s_axis_tdata == CH_READ) begin
                        n_kind  = K_READ;
                        n_phase = PH_INDEX;
                    end else begin
                        n_kind  = K_OTHER;
                        n_phase = PH_SKIP;
                    end
                end
                PH_INDEX: begin
                    if (is_digit) begin
                        n_idx = (idx_mac > 12'(IDX_SAT)) ? IDX_SAT : idx_mac[7:0];
                    end else begin
                        n_phase = (r_kind == K_WRITE) ? PH_VALUE : PH_SKIP;
                    end
                end
                PH_VALUE: begin
                    if (is_digit) begin
                        n_value = val_mac;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // outputs: command leaves on the final byte, taken from the updated accumulators
    always_comb begin
        o_push         = fin && (n_kind == K_WRITE || n_kind == K_READ)
                         && (n_idx < 8'(REG_COUNT));
        o_cmd.is_write = (n_kind == K_WRITE);
        o_cmd.idx      = n_idx[IDX_W-1:0];
        o_cmd.value    = n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin) begin
            r_phase <= PH_CMD;
            r_kind  <= K_NONE;
            r_idx   <= '0;
            r_value <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_idx   <= n_idx;
            r_value <= n_value;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acp_fifo.sv =====
// short command queue between front and back end
// first-word fall-through, count based; uses acp_pkg
`default_nettype none

module acp_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  acp_pkg::t_cmd       i_data,
    input  wire                 i_pop,
    output acp_pkg::t_cmd       o_data,
    output logic                o_full,
    output logic                o_empty
);
    import acp_pkg::*;

    t_cmd                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, r_rd;
    logic [FIFO_CNT_W-1:0]  r_cnt;
    logic                   do_push, do_pop;

    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + FIFO_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acp_back.sv =====
// back end: holding register file, write execution and read reply generation
// value to decimal by a 16-step shift-add-3 loop; uses acp_pkg
`default_nettype none

module acp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  acp_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] tx_byte
    output logic                m_axis_tlast    // reply_last
);
    import acp_pkg::*;

    logic [15:0]  r_regs [REG_COUNT];

    t_bstate      r_state, n_state;
    t_seg         r_seg, n_seg;
    logic [2:0]   r_ptr, n_ptr;
    logic [15:0]  r_bin;
    logic [19:0]  r_bcd;
    logic [19:0]  adj;
    logic [3:0]   r_cnt;
    logic [3:0]   r_tens, r_ones;
    logic [2:0]   top;

    logic         r_o_valid, r_o_last;
    logic [7:0]   r_o_data;

    logic         out_free;
    logic         load_rd;
    logic         do_wr;
    logic         emit;
    logic [7:0]   emit_byte;
    logic         emit_last;
    logic [3:0]   cmd_tens;
    logic [6:0]   cmd_idx7;

    assign out_free = !r_o_valid || m_axis_tready;
    assign cmd_idx7 = 7'(i_cmd.idx);
    assign cmd_tens = f_tens(cmd_idx7);

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            adj[j*4 +: 4] = (r_bcd[j*4 +: 4] >= 4'd5) ? r_bcd[j*4 +: 4] + 4'd3
                                                      : r_bcd[j*4 +: 4];
        end
    end

    // highest nonzero value digit, zero prints as one digit
    always_comb begin
        top = 3'd0;
        for (int j = 1; j < 5; j++) begin
            if (r_bcd[j*4 +: 4] != 4'd0) begin
                top = 3'(j);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_ptr   = r_ptr;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty && !i_cmd.is_write) begin
                    n_state = BK_CONV;
                end
            end
            BK_CONV: begin
                if (r_cnt == 4'd15) begin
                    n_state = BK_SEND;
                    n_seg   = SEG_W;
                    n_ptr   = 3'd0;
                end
            end
            BK_SEND: begin
                if (out_free) begin
                    case (r_seg)
                        SEG_W: begin
                            n_seg = SEG_IDX;
                            n_ptr = (r_tens != 4'd0) ? 3'd1 : 3'd0;
                        end
                        SEG_IDX: begin
                            if (r_ptr == 3'd0) begin
                                n_seg = SEG_COLON;
                            end else begin
                                n_ptr = r_ptr - 3'd1;
                            end
                        end
                        SEG_COLON: begin
                            n_seg = SEG_VAL;
                            n_ptr = top;
                        end
                        SEG_VAL: begin
                            if (r_ptr == 3'd0) begin
                                n_state = BK_IDLE;
                            end else begin
                                n_ptr = r_ptr - 3'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop     = (r_state == BK_IDLE) && !i_empty;
        do_wr     = o_pop && i_cmd.is_write;
        load_rd   = o_pop && !i_cmd.is_write;
        emit      = (r_state == BK_SEND) && out_free;
        emit_last = 1'b0;
        case (r_seg)
            SEG_W:     emit_byte = CH_WRITE;
            SEG_IDX:   emit_byte = CH_ZERO + {4'b0, (r_ptr[0] ? r_tens : r_ones)};
            SEG_COLON: emit_byte = CH_COLON;
            SEG_VAL: begin
                emit_byte = CH_ZERO + {4'b0, r_bcd[{r_ptr, 2'b00} +: 4]};
                emit_last = (r_ptr == 3'd0);
            end
            default:   emit_byte = CH_WRITE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= (i >= SERVO_LO && i <= SERVO_HI) ? RESET_SERVO : 16'd0;
            end
        end else if (do_wr) begin
            r_regs[i_cmd.idx] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_seg   <= SEG_W;
            r_ptr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_ptr   <= n_ptr;
            if (load_rd) begin
                r_cnt <= '0;
            end else if (r_state == BK_CONV) begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rd) begin
            r_bin  <= r_regs[i_cmd.idx];
            r_bcd  <= '0;
            r_tens <= cmd_tens;
            r_ones <= 4'(cmd_idx7 - 7'(cmd_tens) * 7'd10);
        end else if (r_state == BK_CONV) begin
            r_bcd <= {adj[18:0], r_bin[15]};
            r_bin <= {r_bin[14:0], 1'b0};
        end
    end

    // output register parts the generator from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_data <= emit_byte;
            r_o_last <= emit_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("command popped from empty queue");

    a_valid_from_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == BK_SEND))
        else $error("reply item produced outside send phase");

    a_conv_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CONV && $past(r_state == BK_CONV))
            |-> r_cnt == $past(r_cnt) + 4'd1)
        else $error("conversion step counter skipped");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !o_pop)
        else $error("command taken while a reply is in progress");

endmodule

`default_nettype wire

// ===== rtl/core/ascii_register_command_parser.sv =====
// top level of the ascii register command parser: front end, command queue, back end
// depends on acp_pkg, acp_front, acp_fifo and acp_back
//
// Usage:
//   Slave stream carries received bytes, one item per byte; tlast marks the final byte
//   of a message. "W<idx><sep><val>" writes a 16-bit holding register, "R<idx>" asks
//   for the reply "W<idx>:<val>" in decimal on the master stream, tlast on its last
//   byte. Other messages and out-of-range indexes produce nothing.
//   Throughput: the input takes one byte per cycle while the queue has room; a message
//   is decoded as its last byte is taken and the command enters a 4-entry queue. The back
//   end retires a write as it pops it. A read goes through the shift-add-3 decimal
//   conversion, then sends one reply byte per cycle while m_axis_tready is high; the back
//   end pops no new command until its last reply byte is emitted. The queue depth and
//   this conversion loop set the rate of reads that can be sustained; s_axis_tready
//   falls only while the queue is full.
//   Reset: synchronous, active low; the register file returns to 1500 in slots 2 to 6
//   and 0 elsewhere, any partial message and queued commands are discarded.
//   A stall on m_axis_tready holds the output register and pauses the reply; input
//   bytes keep being taken until the queue fills.
`default_nettype none

module ascii_register_command_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire         s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast    // reply_last
);
    import acp_pkg::*;

    t_cmd  push_cmd, head_cmd;
    logic  push, pop, full, empty;

    acp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    acp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    acp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for ascii_register_command_parser: streams command messages one byte per item
// and checks every read reply byte against a behavioral parser kept here; needs acp_pkg and rtl

module tb;
    import acp_pkg::*;

    localparam int RADIX          = 10;
    localparam int RANDOM_BYTES   = 370;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } serial_byte_t;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'd0;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    wire        s_axis_tready;
    wire        m_axis_tvalid;
    wire  [7:0] m_axis_tdata;
    wire        m_axis_tlast;

    serial_byte_t rx_pending[$];
    serial_byte_t reply_expected[$];
    logic [7:0]   msg_bytes[$];

    // parser state mirrored from the accepted byte stream
    logic [15:0] holding[REG_COUNT];
    t_phase      msg_phase;
    t_kind       msg_kind;
    logic [7:0]  msg_index;
    logic [15:0] msg_value;
    int          msg_count;

    int errors        = 0;
    int rx_queued     = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int idle_cycles   = 0;
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;

    ascii_register_command_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),         // [7:0] rx_byte
        .s_axis_tlast  (s_last),         // end_of_message
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] tx_byte
        .m_axis_tlast  (m_axis_tlast)    // reply_last
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void clear_message();
        msg_phase = PH_CMD;
        msg_kind  = K_NONE;
        msg_index = 8'd0;
        msg_value = 16'd0;
        msg_count = 0;
    endfunction

    function automatic void reset_parser_model();
        for (int i = 0; i < REG_COUNT; i++)
            holding[i] = (i >= SERVO_LO && i <= SERVO_HI) ? RESET_SERVO : 16'd0;
        clear_message();
    endfunction

    function automatic void push_reply_decimal(int v, bit last);
        string        s;
        serial_byte_t sb;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) begin
            sb.data = s[i];
            sb.last = last && (i == s.len() - 1);
            reply_expected.push_back(sb);
        end
    endfunction

    function automatic void predict_rx_byte(logic [7:0] b, logic last);
        bit           digit;
        int           nx;
        serial_byte_t sb;
        digit = (b >= CH_ZERO && b <= CH_NINE);
        // bytes past the buffer length are dropped, the last mark still counts
        if (msg_count < MSG_BYTES) begin
            msg_count++;
            case (msg_phase)
                PH_CMD: begin
                    if (b == CH_WRITE) begin
                        msg_kind  = K_WRITE;
                        msg_phase = PH_INDEX;
                    end else if (b == CH_READ) begin
                        msg_kind  = K_READ;
                        msg_phase = PH_INDEX;
                    end else begin
                        msg_kind  = K_OTHER;
                        msg_phase = PH_SKIP;
                    end
                end
                PH_INDEX: begin
                    if (digit) begin
                        nx = int'(msg_index) * RADIX + int'(b - CH_ZERO);
                        msg_index = (nx > int'(IDX_SAT)) ? IDX_SAT : nx[7:0];
                    end else begin
                        msg_phase = (msg_kind == K_WRITE) ? PH_VALUE : PH_SKIP;
                    end
                end
                PH_VALUE: begin
                    if (digit) begin
                        nx = int'(msg_value) * RADIX + int'(b - CH_ZERO);
                        msg_value = nx[15:0];
                    end else begin
                        msg_phase = PH_SKIP;
                    end
                end
                default: ;
            endcase
        end
        if (last) begin
            if (msg_index < REG_COUNT) begin
                if (msg_kind == K_WRITE) begin
                    holding[msg_index] = msg_value;
                end else if (msg_kind == K_READ) begin
                    sb.data = CH_WRITE;
                    sb.last = 1'b0;
                    reply_expected.push_back(sb);
                    push_reply_decimal(msg_index, 1'b0);
                    sb.data = CH_COLON;
                    reply_expected.push_back(sb);
                    push_reply_decimal(holding[msg_index], 1'b1);
                end
            end
            clear_message();
        end
    endfunction

    // message building: bytes collect in msg_bytes, flush marks the last one
    function automatic void flush_message();
        serial_byte_t sb;
        foreach (msg_bytes[i]) begin
            sb.data = msg_bytes[i];
            sb.last = (i == msg_bytes.size() - 1);
            rx_pending.push_back(sb);
        end
        rx_queued += msg_bytes.size();
        msg_bytes.delete();
    endfunction

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
    endfunction

    function automatic void send_text(string s);
        append_text(s);
        flush_message();
    endfunction

    function automatic void append_dec(int v);
        append_text($sformatf("%0d", v));
    endfunction

    function automatic void append_noise(int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= CH_ZERO && b <= CH_NINE);
        return b;
    endfunction

    function automatic void append_index();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick != 0) begin
            if (pick < 3)
                msg_bytes.push_back(CH_ZERO);
            if (pick < 15)
                append_dec($urandom_range(0, REG_COUNT - 1));
            else if (pick < 18)
                append_dec($urandom_range(REG_COUNT, 99));
            else
                append_dec($urandom_range(100, 99999));
        end
    endfunction

    function automatic void append_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            append_dec($urandom_range(0, 65535));
        else if (pick < 8)
            append_dec($urandom_range(0, 999999));
        else if (pick < 9)
            append_dec($urandom_range(0, 9));
    endfunction

    function automatic void build_random_message();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            msg_bytes.push_back(CH_READ);
            append_index();
            if ($urandom_range(0, 6) == 0)
                append_noise($urandom_range(1, 4));
        end else if (pick < 75) begin
            msg_bytes.push_back(CH_WRITE);
            append_index();
            msg_bytes.push_back(non_digit());
            append_value();
            if ($urandom_range(0, 6) == 0)
                append_noise($urandom_range(1, 4));
        end else if (pick < 86) begin
            append_noise($urandom_range(1, 6));
        end else if (pick < 95) begin
            msg_bytes.push_back($urandom_range(0, 1) ? CH_WRITE : CH_READ);
            append_noise($urandom_range(0, 5));
        end else begin
            // long digit run that can run past the message buffer
            msg_bytes.push_back(pick[0] ? CH_WRITE : CH_READ);
            append_index();
            msg_bytes.push_back(non_digit());
            repeat ($urandom_range(18, 30))
                msg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    task automatic wait_drained();
        while (rx_pending.size() > 0 || s_valid)
            @(negedge i_clk);
        while (reply_expected.size() > 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        serial_byte_t nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_axis_tready)
                predict_rx_byte(s_data, s_last);
            if (!s_valid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    nxt = rx_pending.pop_front();
                    s_valid  <= 1'b1;
                    s_data   <= nxt.data;
                    s_last   <= nxt.last;
                    send_gap <= sender_idles ? idle_len() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // reply monitor and receiver stalls
    always @(posedge i_clk) begin
        serial_byte_t want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_ready) begin
                if (reply_expected.size() == 0) begin
                    $display("%0t: unexpected reply item: byte %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    want = reply_expected.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        $display("%0t: reply mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 $time, want.data, want.last, m_axis_tdata, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left   <= LONG_HOLD;
                m_ready     <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_axis_tvalid && m_ready && receiver_idles)
                    recv_gap <= idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int random_start;
        reset_parser_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset value, extremes, short and empty fields, other commands
        send_text("R2");
        send_text("W0,65535");
        send_text("R");
        send_text("W");
        send_text("W5");
        send_text("R5");
        send_text("X5");
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hff);
        flush_message();
        send_text("R14");
        send_text("W:7");
        send_text("R0");
        wait_drained();

        // receiver holds off while reads keep coming, so the command queue fills
        hold_requests++;
        repeat (4) @(negedge i_clk);
        for (int i = 0; i < 10; i++) begin
            msg_bytes.push_back(CH_READ);
            append_dec(i % REG_COUNT);
            flush_message();
        end
        wait_drained();

        random_start = rx_queued;
        while (rx_queued - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 11) == 0) begin
                sender_idles   = $urandom_range(0, 1);
                receiver_idles = $urandom_range(0, 1);
            end
            build_random_message();
            flush_message();
            while (rx_pending.size() > 12)
                @(negedge i_clk);
        end
        wait_drained();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
